[rtl/core/slc_pkg.sv]
`timescale 1ns / 1ps
package slc_pkg;

    // Build defaults
    localparam int MAX_SETS_DEF   = 1024;
    localparam int WAYS_DEF       = 4;
    localparam int WORD_BYTES_DEF = 4;

    // Register reset values
    localparam logic [2:0] BLK_LOG2_RST = 3'd4;
    localparam logic [3:0] SETS_LOG2_RST = 4'd6;
    localparam logic [2:0] WAYS_USE_RST = 3'd1;

    // Register indexes
    localparam logic [1:0] REG_BLK_LOG2  = 2'd0;
    localparam logic [1:0] REG_SETS_LOG2 = 2'd1;
    localparam logic [1:0] REG_WAYS_USE  = 2'd2;

    // Access kinds; code three acts as a data load
    localparam logic [1:0] CMD_INST  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_STORE = 2'd2;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 176;

    typedef struct packed {
        logic is_inst;
        logic is_store;
    } acc_kind_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EVAL
    } back_state_t;

    // Saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? COUNT_MAX : s[31:0];
    endfunction

endpackage

[rtl/core/set_assoc_lru_cache_tag_model.sv]
// m_tvalid is registered: an accepted item is queued, its set row is read, then it is evaluated.
// The back end takes a new item only after the last one is evaluated and its row written back.
// Reset: synchronous active-low; clears counters, config to defaults, then runs a
// clearing pass over every set of the valid memory during which s_tready stays low.
`timescale 1ns / 1ps
module set_assoc_lru_cache_tag_model #(
    parameter int MAX_SETS   = slc_pkg::MAX_SETS_DEF,
    parameter int WAYS       = slc_pkg::WAYS_DEF,
    parameter int WORD_BYTES = slc_pkg::WORD_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: address[31:0], command[33:32], zero fill
    input  logic [slc_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: hit, filled_empty, replaced, copy_back, set_number[10], way_number[2],
    // inst_miss_total, data_miss_total, inst_replace_total, data_replace_total,
    // copy_back_words (32 each), from bit 0 up
    output logic [slc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import slc_pkg::*;

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int SMAX  = $clog2(MAX_SETS + 1) - 1;
    localparam int NW_W  = $clog2(WAYS + 1);

    logic [2:0] blk_reg;
    logic [3:0] sets_reg;
    logic [2:0] ways_reg;
    logic       wr_en;
    logic [2:0] eff_bl;
    logic [4:0] eff_sl;
    logic [NW_W-1:0] eff_nw;
    logic       clear_done, q_valid, q_pop;
    logic [31:0] q_tag;
    logic [SET_W-1:0] q_set;
    acc_kind_t  q_kind;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg  <= BLK_LOG2_RST;
            sets_reg <= SETS_LOG2_RST;
            ways_reg <= WAYS_USE_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_BLK_LOG2:  blk_reg  <= pwdata[2:0];
                REG_SETS_LOG2: sets_reg <= pwdata[3:0];
                REG_WAYS_USE:  ways_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BLK_LOG2:  prdata = {29'd0, blk_reg};
            REG_SETS_LOG2: prdata = {28'd0, sets_reg};
            REG_WAYS_USE:  prdata = {29'd0, ways_reg};
            default:       prdata = '0;
        endcase
    end

    // Clamp config to usable values
    always_comb begin
        eff_bl = (blk_reg < 3'd2) ? 3'd2 : blk_reg;
        eff_sl = (int'(sets_reg) > SMAX) ? 5'(SMAX) : {1'b0, sets_reg};
        if (ways_reg == 3'd0) begin
            eff_nw = NW_W'(1);
        end else if (int'(ways_reg) > WAYS) begin
            eff_nw = NW_W'(WAYS);
        end else begin
            eff_nw = NW_W'(ways_reg);
        end
    end

    slc_front #(
        .SET_W    (SET_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .eff_bl     (eff_bl),
        .eff_sl     (eff_sl),
        .clear_done (clear_done),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_tag      (q_tag),
        .q_set      (q_set),
        .q_kind     (q_kind)
    );

    slc_back #(
        .MAX_SETS   (MAX_SETS),
        .WAYS       (WAYS),
        .WORD_BYTES (WORD_BYTES),
        .SET_W      (SET_W),
        .NW_W       (NW_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .eff_bl     (eff_bl),
        .eff_nw     (eff_nw),
        .clear_done (clear_done),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_tag      (q_tag),
        .q_set      (q_set),
        .q_kind     (q_kind),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

[rtl/core/slc_front.sv]
`timescale 1ns / 1ps
module slc_front #(
    parameter int SET_W    = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [2:0]                eff_bl,
    input  logic [4:0]                eff_sl,
    input  logic                      clear_done,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // s_tdata: address[31:0], command[33:32], zero fill
    input  logic [slc_pkg::IN_DATA_W-1:0] s_tdata,
    output logic                      q_valid,
    input  logic                      q_pop,
    output logic [31:0]               q_tag,
    output logic [SET_W-1:0]          q_set,
    output slc_pkg::acc_kind_t        q_kind
);
    import slc_pkg::*;

    logic [31:0]      addr;
    logic [1:0]       cmd;
    logic [31:0]      set_full;
    logic [31:0]      tag_c;
    logic [5:0]       tag_sh;
    acc_kind_t        kind_c;
    logic             push;

    logic [31:0]      tag_q   [2];
    logic [SET_W-1:0] set_q   [2];
    acc_kind_t        kind_q  [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;

    // Split address into set and tag
    always_comb begin
        addr     = s_tdata[31:0];
        cmd      = s_tdata[33:32];
        set_full = (addr >> eff_bl) & 32'((33'd1 << eff_sl) - 33'd1);
        tag_sh   = 6'(eff_bl) + 6'(eff_sl);
        tag_c    = addr >> tag_sh;
        kind_c.is_inst  = (cmd == CMD_INST);
        kind_c.is_store = (cmd == CMD_STORE);
    end

    assign s_tready = clear_done && (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    // Two-entry queue toward the back end
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            tag_q[wr_ptr_reg]  <= tag_c;
            set_q[wr_ptr_reg]  <= SET_W'(set_full);
            kind_q[wr_ptr_reg] <= kind_c;
        end
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_tag   = tag_q[rd_ptr_reg];
    assign q_set   = set_q[rd_ptr_reg];
    assign q_kind  = kind_q[rd_ptr_reg];

endmodule

[rtl/core/slc_back.sv]
`timescale 1ns / 1ps
module slc_back #(
    parameter int MAX_SETS   = slc_pkg::MAX_SETS_DEF,
    parameter int WAYS       = slc_pkg::WAYS_DEF,
    parameter int WORD_BYTES = slc_pkg::WORD_BYTES_DEF,
    parameter int SET_W      = 10,
    parameter int NW_W       = 3
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [2:0]                 eff_bl,
    input  logic [NW_W-1:0]            eff_nw,
    output logic                       clear_done,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  logic [31:0]                q_tag,
    input  logic [SET_W-1:0]           q_set,
    input  slc_pkg::acc_kind_t         q_kind,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // m_tdata: hit[0], filled_empty[1], replaced[2], copy_back[3], set_number[13:4],
    // way_number[15:14], inst_miss_total[47:16], data_miss_total[79:48],
    // inst_replace_total[111:80], data_replace_total[143:112], copy_back_words[175:144]
    output logic [slc_pkg::OUT_DATA_W-1:0] m_tdata
);
    import slc_pkg::*;

    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AGE_W = WAY_W;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

    typedef logic [WAYS-1:0][AGE_W-1:0] age_row_t;
    typedef logic [WAYS-1:0][31:0]      tag_row_t;

    // Per-set memories
    logic [WAYS-1:0] valid_mem [MAX_SETS];
    logic [WAYS-1:0] dirty_mem [MAX_SETS];
    age_row_t        age_mem   [MAX_SETS];
    tag_row_t        tag_mem   [MAX_SETS];

    logic [WAYS-1:0] valid_rd_reg, dirty_rd_reg;
    age_row_t        age_rd_reg;
    tag_row_t        tag_rd_reg;

    back_state_t      state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [31:0]      tag_reg;
    logic [SET_W-1:0] set_reg;
    acc_kind_t        kind_reg;

    logic [31:0] imiss_reg, dmiss_reg, irep_reg, drep_reg, wb_reg;
    logic [31:0] imiss_next, dmiss_next, irep_next, drep_next, wb_next;
    logic        out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic            rd_en, eval_en, out_free;
    logic            hit, found, cback;
    logic [WAY_W-1:0] way;
    logic [AGE_W-1:0] ref_age;
    logic [WAYS-1:0] valid_new, dirty_new;
    age_row_t        age_new;
    tag_row_t        tag_new;
    logic [31:0]     words;

    // Words per block, from the block size in use
    always_comb begin
        case (eff_bl)
            3'd3:    words = 32'(8 / WORD_BYTES);
            3'd4:    words = 32'(16 / WORD_BYTES);
            3'd5:    words = 32'(32 / WORD_BYTES);
            3'd6:    words = 32'(64 / WORD_BYTES);
            3'd7:    words = 32'(128 / WORD_BYTES);
            default: words = 32'(4 / WORD_BYTES);
        endcase
    end

    assign out_free   = !out_valid_reg || m_tready;
    assign clear_done = (state_reg != BK_CLEAR);

    // Sequencer: clear pass, read, evaluate
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        rd_en        = 1'b0;
        eval_en      = 1'b0;
        case (state_reg)
            BK_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_W'(MAX_SETS - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (q_valid) begin
                    rd_en      = 1'b1;
                    state_next = BK_EVAL;
                end
            end
            BK_EVAL: begin
                if (out_free) begin
                    eval_en    = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign q_pop = rd_en;

    // Lookup and LRU update on the read row
    always_comb begin
        hit       = 1'b0;
        found     = 1'b0;
        cback     = 1'b0;
        way       = '0;
        ref_age   = '0;
        valid_new = valid_rd_reg;
        dirty_new = dirty_rd_reg;
        age_new   = age_rd_reg;
        tag_new   = tag_rd_reg;
        for (int w = 0; w < WAYS; w++) begin
            if (!hit && (w < int'(eff_nw)) && valid_rd_reg[w] && tag_rd_reg[w] == tag_reg) begin
                hit = 1'b1;
                way = WAY_W'(w);
            end
        end
        if (hit) begin
            ref_age = age_rd_reg[way];
            for (int w = 0; w < WAYS; w++) begin
                if ((w < int'(eff_nw)) && (WAY_W'(w) != way) && valid_rd_reg[w]
                        && age_rd_reg[w] < ref_age) begin
                    age_new[w] = age_rd_reg[w] + 1'b1;
                end
            end
            age_new[way] = '0;
            if (kind_reg.is_store) begin
                dirty_new[way] = 1'b1;
            end
        end else begin
            for (int w = 0; w < WAYS; w++) begin
                if (!found && (w < int'(eff_nw)) && !valid_rd_reg[w]) begin
                    found = 1'b1;
                    way   = WAY_W'(w);
                end
            end
            if (found) begin
                for (int w = 0; w < WAYS; w++) begin
                    if ((w < int'(eff_nw)) && valid_rd_reg[w] && age_rd_reg[w] < AGE_MAX) begin
                        age_new[w] = age_rd_reg[w] + 1'b1;
                    end
                end
            end else begin
                // Oldest way, lowest number on a tie
                for (int w = 0; w < WAYS; w++) begin
                    if ((w < int'(eff_nw)) && age_rd_reg[w] > ref_age) begin
                        ref_age = age_rd_reg[w];
                        way     = WAY_W'(w);
                    end
                end
                cback = dirty_rd_reg[way];
                for (int w = 0; w < WAYS; w++) begin
                    if ((w < int'(eff_nw)) && (WAY_W'(w) != way) && valid_rd_reg[w]
                            && age_rd_reg[w] < ref_age) begin
                        age_new[w] = age_rd_reg[w] + 1'b1;
                    end
                end
            end
            tag_new[way]   = tag_reg;
            valid_new[way] = 1'b1;
            dirty_new[way] = kind_reg.is_store;
            age_new[way]   = '0;
        end
    end

    // Counters
    always_comb begin
        imiss_next = imiss_reg;
        dmiss_next = dmiss_reg;
        irep_next  = irep_reg;
        drep_next  = drep_reg;
        wb_next    = wb_reg;
        if (!hit) begin
            if (kind_reg.is_inst) begin
                imiss_next = sat_add(imiss_reg, 32'd1);
            end else begin
                dmiss_next = sat_add(dmiss_reg, 32'd1);
            end
            if (!found) begin
                if (kind_reg.is_inst) begin
                    irep_next = sat_add(irep_reg, 32'd1);
                end else begin
                    drep_next = sat_add(drep_reg, 32'd1);
                end
                if (cback) begin
                    wb_next = sat_add(wb_reg, words);
                end
            end
        end
        out_valid_next = eval_en ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            imiss_reg     <= '0;
            dmiss_reg     <= '0;
            irep_reg      <= '0;
            drep_reg      <= '0;
            wb_reg        <= '0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (eval_en) begin
                imiss_reg <= imiss_next;
                dmiss_reg <= dmiss_next;
                irep_reg  <= irep_next;
                drep_reg  <= drep_next;
                wb_reg    <= wb_next;
            end
        end
    end

    // Item latch and result register
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            tag_reg  <= q_tag;
            set_reg  <= q_set;
            kind_reg <= q_kind;
        end
        if (eval_en) begin
            out_data_reg <= {wb_next, drep_next, irep_next, dmiss_next, imiss_next,
                             2'(way), 10'(set_reg), cback, !hit && !found,
                             !hit && found, hit};
        end
    end

    // Valid memory: cleared after reset
    always_ff @(posedge aclk) begin
        if (state_reg == BK_CLEAR) begin
            valid_mem[clr_cnt_reg] <= '0;
        end else if (eval_en) begin
            valid_mem[set_reg] <= valid_new;
        end
        if (rd_en) begin
            valid_rd_reg <= valid_mem[q_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (eval_en) begin
            dirty_mem[set_reg] <= dirty_new;
            age_mem[set_reg]   <= age_new;
            tag_mem[set_reg]   <= tag_new;
        end
        if (rd_en) begin
            dirty_rd_reg <= dirty_mem[q_set];
            age_rd_reg   <= age_mem[q_set];
            tag_rd_reg   <= tag_mem[q_set];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_cback_is_replace: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[3] || m_tdata[2]))
        else $error("copy-back without replacement");
    a_one_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot({m_tdata[0], m_tdata[1], m_tdata[2]}))
        else $error("result not exactly one of hit, fill, replace");
    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_CLEAR) |-> !q_pop)
        else $error("queue popped during clear pass");
    a_eval_done: assert property (@(posedge aclk) disable iff (!aresetn)
        eval_en |=> (state_reg == BK_IDLE) && m_tvalid)
        else $error("evaluation did not post a result");

endmodule
